@@ hdl/mstb_pkg.sv @@
// Package: widths, command and status codes, and shared structs of the timer bank.
`default_nettype none
package mstb_pkg;

	localparam int FUNC_W   = 4;
	localparam int HANDLE_W = 8;
	localparam int AMOUNT_W = 32;
	localparam int TIME_W   = 27;
	localparam int STATUS_W = 2;
	localparam int ID_W     = 5;

	localparam logic [31:0] MS_PER_DAY = 32'd86400000;
	localparam logic [31:0] MS_PER_S   = 32'd1000;
	localparam logic [31:0] S_PER_DAY  = MS_PER_DAY / MS_PER_S;

	localparam logic [FUNC_W-1:0] FN_ALLOC      = 4'd0;
	localparam logic [FUNC_W-1:0] FN_FREE       = 4'd1;
	localparam logic [FUNC_W-1:0] FN_SET_MS     = 4'd2;
	localparam logic [FUNC_W-1:0] FN_SET_S      = 4'd3;
	localparam logic [FUNC_W-1:0] FN_RESTART    = 4'd4;
	localparam logic [FUNC_W-1:0] FN_QUERY      = 4'd5;
	localparam logic [FUNC_W-1:0] FN_CANCEL     = 4'd6;
	localparam logic [FUNC_W-1:0] FN_CANCEL_ALL = 4'd7;
	localparam logic [FUNC_W-1:0] FN_TICK       = 4'd8;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_HANDLE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TIME    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd3;

	// Command as broadcast to every cell during a walk.
	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [HANDLE_W-1:0] handle;
		logic                mode;
		logic                notify;
		logic [TIME_W-1:0]   now;
		logic [31:0]         now_day;   // now + one day, for a clock that went back
		logic [TIME_W-1:0]   length;    // armed length in ms, zero already made 1
		logic                arm_ok;    // set command passed its range check
		logic [STATUS_W-1:0] status;    // status decided at accept
	} cmd_t;

	// Data handed from cell to cell along with the walk token.
	typedef struct packed {
		logic            found;
		logic [ID_W-1:0] id;
		logic            running;
	} carry_t;

endpackage : mstb_pkg
`default_nettype wire

@@ hdl/mstb_if.sv @@
// Interfaces: command and response channels of the timer bank.
`default_nettype none
interface mstb_cmd_if
	import mstb_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [HANDLE_W-1:0] handle;
	logic                mode;
	logic [AMOUNT_W-1:0] amount;
	logic [TIME_W-1:0]   now_ms;
	logic                notify;

	modport source (output valid, func, handle, mode, amount, now_ms, notify, input ready);
	modport sink   (input valid, func, handle, mode, amount, now_ms, notify, output ready);
endinterface : mstb_cmd_if

interface mstb_rsp_if
	import mstb_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     timer_id;
	logic                running;
	logic                fired;
	logic                last;

	modport source (output valid, status, timer_id, running, fired, last, input ready);
	modport sink   (input valid, status, timer_id, running, fired, last, output ready);
endinterface : mstb_rsp_if
`default_nettype wire

@@ hdl/mstb_cell.sv @@
// One timer cell: holds a timer's state and acts on the command as the walk token passes.
`default_nettype none
module mstb_cell
	import mstb_pkg::*;
#(
	parameter int IDX = 0
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   adv,
	input  wire cmd_t   cmd,
	input  wire logic   tok_in,
	input  wire carry_t carry_in,
	output logic        tok,
	output carry_t      carry,
	output logic        fire
);

	logic              in_use_q, active_q, periodic_q, reports_q, tok_q;
	logic [TIME_W-1:0] start_q, len_q;
	carry_t            carry_q;

	logic              act, hit, expired;
	logic              in_use_nx, active_nx, periodic_nx, reports_nx;
	logic              load_start, load_len;
	logic [31:0]       elapsed;
	carry_t            carry_nx;

	assign act = tok_in && adv;
	assign hit = (cmd.handle == HANDLE_W'(IDX));

	// elapsed time, wrapped across midnight when the clock went back
	always_comb begin
		if (cmd.now < start_q) begin
			elapsed = cmd.now_day - {5'd0, start_q};
		end else begin
			elapsed = {5'd0, cmd.now} - {5'd0, start_q};
		end
	end
	assign expired = active_q && (elapsed >= {5'd0, len_q});

	always_comb begin
		in_use_nx   = in_use_q;
		active_nx   = active_q;
		periodic_nx = periodic_q;
		reports_nx  = reports_q;
		load_start  = 1'b0;
		load_len    = 1'b0;
		carry_nx    = carry_in;
		fire        = 1'b0;
		case (cmd.func)
			FN_ALLOC: begin
				if (!carry_in.found && !in_use_q) begin
					in_use_nx      = 1'b1;
					reports_nx     = cmd.notify;
					active_nx      = 1'b0;
					carry_nx.found = 1'b1;
					carry_nx.id    = ID_W'(IDX);
				end
			end
			FN_FREE: begin
				if (hit) begin
					in_use_nx  = 1'b0;
					reports_nx = 1'b0;
					active_nx  = 1'b0;
				end
			end
			FN_SET_MS, FN_SET_S: begin
				if (hit && cmd.arm_ok) begin
					active_nx   = 1'b1;
					periodic_nx = cmd.mode;
					load_start  = 1'b1;
					load_len    = 1'b1;
				end
			end
			FN_RESTART: begin
				load_start = hit;
			end
			FN_QUERY: begin
				if (hit) begin
					carry_nx.running = active_q;
				end
			end
			FN_CANCEL: begin
				if (hit) begin
					active_nx = 1'b0;
				end
			end
			FN_CANCEL_ALL: begin
				active_nx = 1'b0;
			end
			FN_TICK: begin
				if (expired) begin
					if (periodic_q) begin
						load_start = 1'b1;
					end else begin
						active_nx = 1'b0;
					end
					fire = act && reports_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q   <= 1'b0;
			active_q   <= 1'b0;
			periodic_q <= 1'b0;
			reports_q  <= 1'b0;
			tok_q      <= 1'b0;
		end else begin
			if (adv) begin
				tok_q <= tok_in;
			end
			if (act) begin
				in_use_q   <= in_use_nx;
				active_q   <= active_nx;
				periodic_q <= periodic_nx;
				reports_q  <= reports_nx;
			end
		end
	end

	// timer times and the handed-on data carry no reset
	always_ff @(posedge clk) begin
		if (act && load_start) begin
			start_q <= cmd.now;
		end
		if (act && load_len) begin
			len_q <= cmd.length;
		end
		if (adv) begin
			carry_q <= carry_nx;
		end
	end

	assign tok   = tok_q;
	assign carry = carry_q;

endmodule : mstb_cell
`default_nettype wire

@@ hdl/ms_timer_bank_oneshot_periodic.sv @@
// Top level: millisecond timer bank built as a row of timer cells walked by a token.
//
//  channel | dir | words                                        | handshake
//  --------+-----+----------------------------------------------+-------------
//  cmd     | in  | func, handle, mode, amount, now_ms, notify   | valid/ready
//  rsp     | out | status, timer_id, running, fired, last       | valid/ready
//
// Every command walks a token once along the row of NUM_TIMERS cells, one cell a
// cycle whenever the walk is not held, and ends with the command's closing word.
// Reset clears every flag and the walk control; timer times stay undefined until set.
// The walk holds while a response word waits unaccepted; a tick emits one fire word
// per reporting timer that expired, in index order, then its closing word.
// The next command is accepted as soon as the closing word sits in the output register.
`default_nettype none
module ms_timer_bank_oneshot_periodic
	import mstb_pkg::*;
#(
	parameter int NUM_TIMERS = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mstb_cmd_if.sink    cmd,
	mstb_rsp_if.source  rsp
);

	logic                busy_q, start_q, out_valid_q;
	cmd_t                cmd_q;
	cmd_t                cmd_d;
	logic [STATUS_W-1:0] out_status_q;
	logic [ID_W-1:0]     out_id_q;
	logic                out_running_q, out_fired_q, out_last_q;

	logic                accept, adv, fire_any, final_step;
	logic [ID_W-1:0]     fire_id;
	logic [NUM_TIMERS:0] tok_v;
	logic [NUM_TIMERS-1:0] fire_v;
	carry_t              carry_v [NUM_TIMERS+1];
	carry_t              last_carry;

	logic                handle_ok;
	logic [TIME_W-1:0]   sec_ms, ms_amt;
	logic                too_long;

	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = !busy_q;
	// advance the walk only while the output slot is free or being emptied
	assign adv = busy_q && (!out_valid_q || rsp.ready);

	// decode and range-check the command at accept
	assign handle_ok = (cmd.handle < HANDLE_W'(NUM_TIMERS));
	assign sec_ms    = TIME_W'(TIME_W'(cmd.amount[16:0]) * TIME_W'(MS_PER_S));
	assign ms_amt    = (cmd.func == FN_SET_S) ? sec_ms : cmd.amount[TIME_W-1:0];
	assign too_long  = (cmd.func == FN_SET_S) ? (cmd.amount >= S_PER_DAY)
	                                          : (cmd.amount >= MS_PER_DAY);

	always_comb begin
		cmd_d         = '0;
		cmd_d.func    = cmd.func;
		cmd_d.handle  = cmd.handle;
		cmd_d.mode    = cmd.mode;
		cmd_d.notify  = cmd.notify;
		cmd_d.now     = cmd.now_ms;
		cmd_d.now_day = {5'd0, cmd.now_ms} + MS_PER_DAY;
		cmd_d.length  = (ms_amt == '0) ? TIME_W'(1) : ms_amt;
		cmd_d.arm_ok  = !too_long;
		cmd_d.status  = ST_OK;
		case (cmd.func)
			FN_FREE, FN_RESTART, FN_QUERY, FN_CANCEL: begin
				if (!handle_ok) begin
					cmd_d.status = ST_HANDLE;
				end
			end
			FN_SET_MS, FN_SET_S: begin
				if (!handle_ok) begin
					cmd_d.status = ST_HANDLE;
				end else if (too_long) begin
					cmd_d.status = ST_TIME;
				end
			end
			default: begin
			end
		endcase
	end

	// cell row: token and carry enter at cell 0 and leave after the last cell
	assign tok_v[0]   = start_q;
	assign carry_v[0] = '0;

	for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
		mstb_cell #(
			.IDX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cmd      (cmd_q),
			.tok_in   (tok_v[g]),
			.carry_in (carry_v[g]),
			.tok      (tok_v[g+1]),
			.carry    (carry_v[g+1]),
			.fire     (fire_v[g])
		);
	end

	assign last_carry = carry_v[NUM_TIMERS];
	assign final_step = tok_v[NUM_TIMERS] && adv;
	assign fire_any   = |fire_v;

	// only the cell under the token can fire, so an OR of masked indexes picks it
	always_comb begin
		fire_id = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			fire_id = fire_id | (fire_v[i] ? ID_W'(i) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q  <= 1'b1;
				start_q <= 1'b1;
			end else if (adv) begin
				start_q <= 1'b0;
				if (final_step) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				out_valid_q <= fire_any || final_step;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_d;
		end
		if (adv && fire_any) begin
			out_status_q  <= ST_OK;
			out_id_q      <= fire_id;
			out_running_q <= 1'b0;
			out_fired_q   <= 1'b1;
			out_last_q    <= 1'b0;
		end else if (final_step) begin
			out_status_q  <= cmd_q.status;
			out_id_q      <= '0;
			out_running_q <= last_carry.running;
			out_fired_q   <= 1'b0;
			out_last_q    <= 1'b1;
			if (cmd_q.func == FN_ALLOC) begin
				out_status_q <= last_carry.found ? ST_OK : ST_NO_FREE;
				out_id_q     <= last_carry.found ? last_carry.id : '0;
			end
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.timer_id = out_id_q;
	assign rsp.running  = out_running_q;
	assign rsp.fired    = out_fired_q;
	assign rsp.last     = out_last_q;

	// at most one token in the walk
	a_one_token : assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_v))
		else $error("more than one walk token");

	// no token while idle
	a_idle_no_token : assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tok_v == '0))
		else $error("walk token present while idle");

	// cells fire only on a tick and never two at once
	a_fire_tick : assert property (@(posedge clk) disable iff (!arst_n)
		fire_any |-> (cmd_q.func == FN_TICK) && $onehot(fire_v))
		else $error("fire outside a tick");

	// a closing word ends the walk
	a_final_idle : assert property (@(posedge clk) disable iff (!arst_n)
		final_step |=> !busy_q && rsp.valid && rsp.last)
		else $error("walk did not close");

endmodule : ms_timer_bank_oneshot_periodic
`default_nettype wire
